// ===== hw/rtl/dlr_pkg.sv =====
package dlr_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int DASH_BITS_DEF  = 8;
  localparam int PIXEL_W        = 32;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_IDX_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X     = 3'd0,
    REG_START_Y     = 3'd1,
    REG_END_X       = 3'd2,
    REG_END_Y       = 3'd3,
    REG_PIXEL_VALUE = 3'd4,
    REG_DASH_PERIOD = 3'd5
  } cfg_reg_t;

endpackage

// ===== hw/rtl/dlr_if.sv =====
interface dlr_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface dlr_out_if #(
  parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [COORD_BITS-1:0]       pixel_x;
  logic [COORD_BITS-1:0]       pixel_y;
  logic [dlr_pkg::PIXEL_W-1:0] color_out;
  logic                        draw_flag;
  logic                        last_step;
  logic                        idle_flag;

  modport source (output valid, output pixel_x, output pixel_y, output color_out,
                  output draw_flag, output last_step, output idle_flag, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input color_out,
                  input draw_flag, input last_step, input idle_flag, output ready);
endinterface

// ===== hw/rtl/dashed_line_rasterizer_top.sv =====
// dashed line rasterizer
// configuration: write start_x, start_y, end_x, end_y, pixel_value and
// dash_period through cfg_wr_en / cfg_index / cfg_data while the block is idle;
// endpoints take effect at the next restart, pixel value and dash period live
// input channel in_item: one item per tick; restart=1 reloads the line from
// the endpoints and visits its first pixel, restart=0 visits the next pixel
// output channel out_item: exactly one result per input item, carrying the
// pixel coordinate, color, dash draw flag, last-pixel flag and an idle flag
// for ticks with nothing left to visit (then all other fields are zero)
// result register: the result is valid in the cycle after its item is accepted
// throughput: one item per cycle; the whole bresenham step (error add,
// compare, coordinate increment, dash phase) sits between the line state
// registers and the result register
// stall: the result register holds while out_item.ready is low; a new item
// is still taken in the cycle the pending result leaves
// reset (rst_n, synchronous): configuration and line state clear to zero,
// the line is idle and no result is pending
module dashed_line_rasterizer_top #(
  parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
  parameter int DASH_BITS  = dlr_pkg::DASH_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [dlr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dlr_pkg::CFG_DATA_W-1:0] cfg_data,
  dlr_in_if.sink                         in_item,
  dlr_out_if.source                      out_item
);
  import dlr_pkg::*;

  logic [COORD_BITS-1:0] start_x, start_y, end_x, end_y;
  logic [PIXEL_W-1:0]    pixel_value;
  logic [DASH_BITS-1:0]  dash_period;

  dlr_cfg_regs #(
    .COORD_BITS (COORD_BITS),
    .DASH_BITS  (DASH_BITS)
  ) u_cfg_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .pixel_value (pixel_value),
    .dash_period (dash_period)
  );

  dlr_stepper #(
    .COORD_BITS (COORD_BITS),
    .DASH_BITS  (DASH_BITS)
  ) u_stepper (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .pixel_value (pixel_value),
    .dash_period (dash_period),
    .in_item     (in_item),
    .out_item    (out_item)
  );

endmodule

// ===== hw/rtl/dlr_cfg_regs.sv =====
module dlr_cfg_regs #(
  parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
  parameter int DASH_BITS  = dlr_pkg::DASH_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [dlr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dlr_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [COORD_BITS-1:0]          start_x,
  output logic [COORD_BITS-1:0]          start_y,
  output logic [COORD_BITS-1:0]          end_x,
  output logic [COORD_BITS-1:0]          end_y,
  output logic [dlr_pkg::PIXEL_W-1:0]    pixel_value,
  output logic [DASH_BITS-1:0]           dash_period
);
  import dlr_pkg::*;

  logic [COORD_BITS-1:0] start_x_r, start_y_r, end_x_r, end_y_r;
  logic [PIXEL_W-1:0]    pixel_value_r;
  logic [DASH_BITS-1:0]  dash_period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r     <= '0;
      start_y_r     <= '0;
      end_x_r       <= '0;
      end_y_r       <= '0;
      pixel_value_r <= '0;
      dash_period_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_X:     start_x_r     <= cfg_data[COORD_BITS-1:0];
        REG_START_Y:     start_y_r     <= cfg_data[COORD_BITS-1:0];
        REG_END_X:       end_x_r       <= cfg_data[COORD_BITS-1:0];
        REG_END_Y:       end_y_r       <= cfg_data[COORD_BITS-1:0];
        REG_PIXEL_VALUE: pixel_value_r <= cfg_data[PIXEL_W-1:0];
        REG_DASH_PERIOD: dash_period_r <= cfg_data[DASH_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign start_x     = start_x_r;
  assign start_y     = start_y_r;
  assign end_x       = end_x_r;
  assign end_y       = end_y_r;
  assign pixel_value = pixel_value_r;
  assign dash_period = dash_period_r;

endmodule

// ===== hw/rtl/dlr_stepper.sv =====
module dlr_stepper #(
  parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
  parameter int DASH_BITS  = dlr_pkg::DASH_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [COORD_BITS-1:0]       start_x,
  input  logic [COORD_BITS-1:0]       start_y,
  input  logic [COORD_BITS-1:0]       end_x,
  input  logic [COORD_BITS-1:0]       end_y,
  input  logic [dlr_pkg::PIXEL_W-1:0] pixel_value,
  input  logic [DASH_BITS-1:0]        dash_period,
  dlr_in_if.sink                      in_item,
  dlr_out_if.source                   out_item
);
  import dlr_pkg::*;

  // line state
  logic [COORD_BITS-1:0] cur_x_r, cur_y_r, steps_left_r;
  logic [COORD_BITS:0]   error_accum_r;
  logic [DASH_BITS-1:0]  dash_phase_r;
  logic [COORD_BITS-1:0] delta_major_r, delta_minor_r;
  logic                  x_is_major_r, x_negative_r, y_negative_r;

  logic [COORD_BITS-1:0] cur_x_nxt, cur_y_nxt, steps_left_nxt;
  logic [COORD_BITS:0]   error_accum_nxt;
  logic [DASH_BITS-1:0]  dash_phase_nxt;
  logic [COORD_BITS-1:0] delta_major_nxt, delta_minor_nxt;
  logic                  x_is_major_nxt, x_negative_nxt, y_negative_nxt;

  // result register
  logic                  out_valid_r;
  logic [COORD_BITS-1:0] pixel_x_r, pixel_y_r;
  logic [PIXEL_W-1:0]    color_out_r;
  logic                  draw_flag_r, last_step_r, idle_flag_r;

  logic [COORD_BITS-1:0] dx, dy;
  logic [COORD_BITS-1:0] base_x, base_y, base_steps;
  logic [COORD_BITS:0]   base_err, err_sum;
  logic [DASH_BITS-1:0]  base_phase, phase_inc;
  logic                  active, draw, minor_step, step_x, step_y;
  logic                  accept;

  assign in_item.ready = !out_valid_r || out_item.ready;
  assign accept        = in_item.valid && in_item.ready;

  always_comb begin
    dx = '0;
    dy = '0;
    if (in_item.restart) begin
      x_negative_nxt  = end_x < start_x;
      y_negative_nxt  = end_y < start_y;
      dx              = x_negative_nxt ? start_x - end_x : end_x - start_x;
      dy              = y_negative_nxt ? start_y - end_y : end_y - start_y;
      x_is_major_nxt  = dx >= dy;
      delta_major_nxt = x_is_major_nxt ? dx : dy;
      delta_minor_nxt = x_is_major_nxt ? dy : dx;
      base_x          = start_x;
      base_y          = start_y;
      base_err        = {2'b00, delta_major_nxt[COORD_BITS-1:1]};
      base_steps      = delta_major_nxt;
      base_phase      = (dash_period > DASH_BITS'(1)) ? DASH_BITS'(1) : '0;
    end else begin
      x_negative_nxt  = x_negative_r;
      y_negative_nxt  = y_negative_r;
      x_is_major_nxt  = x_is_major_r;
      delta_major_nxt = delta_major_r;
      delta_minor_nxt = delta_minor_r;
      base_x          = cur_x_r;
      base_y          = cur_y_r;
      base_err        = error_accum_r;
      base_steps      = steps_left_r;
      base_phase      = dash_phase_r;
    end

    active = base_steps != '0;
    draw   = (dash_period == '0) || (base_phase >= (dash_period >> 1));

    err_sum    = base_err + {1'b0, delta_minor_nxt};
    minor_step = err_sum >= {1'b0, delta_major_nxt};
    step_x     = x_is_major_nxt || minor_step;
    step_y     = !x_is_major_nxt || minor_step;

    phase_inc = base_phase + DASH_BITS'(1);
    if (dash_period == '0 || phase_inc >= dash_period) begin
      phase_inc = '0;
    end

    if (active) begin
      cur_x_nxt       = !step_x ? base_x :
                        (x_negative_nxt ? base_x - COORD_BITS'(1) : base_x + COORD_BITS'(1));
      cur_y_nxt       = !step_y ? base_y :
                        (y_negative_nxt ? base_y - COORD_BITS'(1) : base_y + COORD_BITS'(1));
      error_accum_nxt = minor_step ? err_sum - {1'b0, delta_major_nxt} : err_sum;
      steps_left_nxt  = base_steps - COORD_BITS'(1);
      dash_phase_nxt  = phase_inc;
    end else begin
      cur_x_nxt       = base_x;
      cur_y_nxt       = base_y;
      error_accum_nxt = base_err;
      steps_left_nxt  = base_steps;
      dash_phase_nxt  = base_phase;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      error_accum_r <= '0;
      steps_left_r  <= '0;
      dash_phase_r  <= '0;
      delta_major_r <= '0;
      delta_minor_r <= '0;
      x_is_major_r  <= 1'b0;
      x_negative_r  <= 1'b0;
      y_negative_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        cur_x_r       <= cur_x_nxt;
        cur_y_r       <= cur_y_nxt;
        error_accum_r <= error_accum_nxt;
        steps_left_r  <= steps_left_nxt;
        dash_phase_r  <= dash_phase_nxt;
        delta_major_r <= delta_major_nxt;
        delta_minor_r <= delta_minor_nxt;
        x_is_major_r  <= x_is_major_nxt;
        x_negative_r  <= x_negative_nxt;
        y_negative_r  <= y_negative_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pixel_x_r   <= active ? base_x : '0;
      pixel_y_r   <= active ? base_y : '0;
      color_out_r <= active ? pixel_value : '0;
      draw_flag_r <= active && draw;
      last_step_r <= active && (base_steps == COORD_BITS'(1));
      idle_flag_r <= !active;
    end
  end

  assign out_item.valid     = out_valid_r;
  assign out_item.pixel_x   = pixel_x_r;
  assign out_item.pixel_y   = pixel_y_r;
  assign out_item.color_out = color_out_r;
  assign out_item.draw_flag = draw_flag_r;
  assign out_item.last_step = last_step_r;
  assign out_item.idle_flag = idle_flag_r;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_item.ready |-> out_valid_r)
    else $error("input stalled with empty result register");

  a_idle_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && idle_flag_r |-> !draw_flag_r && !last_step_r &&
      pixel_x_r == '0 && pixel_y_r == '0 && color_out_r == '0)
    else $error("idle result carries payload");

  a_idle_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_item.restart && steps_left_r == '0 |=> out_valid_r && idle_flag_r)
    else $error("advance past end of line gave a pixel");

  a_last_step_ends: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_item.restart && steps_left_r == COORD_BITS'(1) |=>
      last_step_r && !idle_flag_r && steps_left_r == '0)
    else $error("final pixel not flagged or line not finished");

  // an idle tick leaves the phase alone, so only a restart or a visited pixel clears it
  a_phase_zero_solid: assert property (@(posedge clk) disable iff (!rst_n)
    accept && dash_period == '0 && (in_item.restart || steps_left_r != '0) |=>
      dash_phase_r == '0)
    else $error("dash phase moved on a solid line");

endmodule
